@@ src/hsv2a_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2a_pkg
// Shared types, constants and helpers for the HSV to ARGB pixel pipeline.
// ----------------------------------------------------------------------------
package hsv2a_pkg;

	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned OUT_TDATA_W = 32;

	localparam logic [7:0]  FULL_SCALE = 8'd255;
	localparam logic [15:0] FRAC_SCALE = 16'd65280;   // 255 * 256
	localparam logic [8:0]  SECTOR_STEPS = 9'd256;

	// hue sector codes (hue_angle[10:8])
	localparam logic [2:0] SEC_R_TO_Y  = 3'd0;
	localparam logic [2:0] SEC_Y_TO_G  = 3'd1;
	localparam logic [2:0] SEC_G_TO_C  = 3'd2;
	localparam logic [2:0] SEC_C_TO_B  = 3'd3;
	localparam logic [2:0] SEC_B_TO_M  = 3'd4;
	localparam logic [2:0] SEC_M_TO_R  = 3'd5;
	localparam logic [2:0] SEC_WRAP    = 3'd6;
	localparam logic [2:0] SEC_BLACK   = 3'd7;

	// after stage 1: first-level products
	typedef struct packed {
		logic [7:0]  alpha;
		logic [2:0]  sector;
		logic [7:0]  bright;
		logic [7:0]  inv_sat;    // 255 - s
		logic [15:0] sat_fr;     // s * fr
		logic [15:0] sat_cfr;    // s * (256 - fr)
	} s1_data_t;

	// after stage 2: brightness products, q/t already divided by 256
	typedef struct packed {
		logic [7:0]  alpha;
		logic [2:0]  sector;
		logic [7:0]  bright;
		logic [15:0] prod_p;
		logic [15:0] prod_q;
		logic [15:0] prod_t;
	} s2_data_t;

	// after stage 3: final color terms
	typedef struct packed {
		logic [7:0] alpha;
		logic [2:0] sector;
		logic [7:0] bright;
		logic [7:0] term_p;
		logic [7:0] term_q;
		logic [7:0] term_t;
	} s3_data_t;

	// floor(y / 255) for 16-bit y below 65280: reciprocal estimate, one correction
	function automatic logic [7:0] div255(input logic [15:0] y);
		logic [16:0] sum;
		logic [8:0]  est;
		logic [16:0] back;
		logic [16:0] rem;
		logic [8:0]  res;
		sum  = {1'b0, y} + {9'b0, y[15:8]};
		est  = sum[16:8];
		back = {est, 8'b0} - {8'b0, est};
		rem  = {1'b0, y} - back;
		res  = (rem >= 17'd255) ? est + 9'd1 : est;
		return res[7:0];
	endfunction

endpackage

@@ src/hsv_to_argb_pixel_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_argb_pixel_top
// HSV plus alpha to packed 32-bit ARGB pixel converter, stream interface.
// ----------------------------------------------------------------------------
// Takes one word per clock while the pipeline advances and returns one ARGB word
// after it has passed the four register stages (two multiply stages, one
// scaling stage, one select/output stage). All stages advance together when
// the output register is empty or being taken, so throughput is one word per
// cycle whenever the downstream side keeps tready high. Hue is in 1/1536 turn
// units; sector 6 wraps to red, sector 7 gives black with alpha kept.
module hsv_to_argb_pixel_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// alpha_in[7:0], hue_angle[18:8], sat_level[26:19], bright_level[34:27], zero pad
	input  logic [hsv2a_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// argb_word[31:0]
	output logic [hsv2a_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

	logic                en;
	logic                valid_s2;
	hsv2a_pkg::s2_data_t data_s2;
	logic                valid_s3;
	hsv2a_pkg::s3_data_t data_s3;

	// whole pipeline moves when the output slot frees up
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	hsv2a_prod u_prod (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (s_axis_tvalid),
		.alpha_in     (s_axis_tdata[7:0]),
		.hue_angle    (s_axis_tdata[18:8]),
		.sat_level    (s_axis_tdata[26:19]),
		.bright_level (s_axis_tdata[34:27]),
		.out_valid    (valid_s2),
		.out_data     (data_s2)
	);

	hsv2a_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s2),
		.in_data   (data_s2),
		.out_valid (valid_s3),
		.out_data  (data_s3)
	);

	hsv2a_mux u_mux (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s3),
		.in_data   (data_s3),
		.out_valid (m_axis_tvalid),
		.argb_word (m_axis_tdata)
	);

endmodule

@@ src/hsv2a_prod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2a_prod
// Stages 1 and 2: saturation/fraction products, then brightness products.
// ----------------------------------------------------------------------------
module hsv2a_prod (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [7:0]           alpha_in,
	input  logic [10:0]          hue_angle,
	input  logic [7:0]           sat_level,
	input  logic [7:0]           bright_level,
	output logic                 out_valid,
	output hsv2a_pkg::s2_data_t  out_data
);

	logic                valid_s1;
	hsv2a_pkg::s1_data_t data_s1;
	logic [8:0]          cfrac;
	logic [16:0]         sat_cfr_w;
	logic [23:0]         mq_w;
	logic [23:0]         mt_w;

	assign cfrac     = hsv2a_pkg::SECTOR_STEPS - {1'b0, hue_angle[7:0]};
	assign sat_cfr_w = {9'b0, sat_level} * {8'b0, cfrac};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1  <= in_valid;
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1.alpha   <= alpha_in;
			data_s1.sector  <= hue_angle[10:8];
			data_s1.bright  <= bright_level;
			data_s1.inv_sat <= hsv2a_pkg::FULL_SCALE - sat_level;
			data_s1.sat_fr  <= {8'b0, sat_level} * {8'b0, hue_angle[7:0]};
			data_s1.sat_cfr <= sat_cfr_w[15:0];
		end
	end

	assign mq_w = {16'b0, data_s1.bright} * {8'b0, hsv2a_pkg::FRAC_SCALE - data_s1.sat_fr};
	assign mt_w = {16'b0, data_s1.bright} * {8'b0, hsv2a_pkg::FRAC_SCALE - data_s1.sat_cfr};

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.alpha  <= data_s1.alpha;
			out_data.sector <= data_s1.sector;
			out_data.bright <= data_s1.bright;
			out_data.prod_p <= {8'b0, data_s1.bright} * {8'b0, data_s1.inv_sat};
			// dividing by 65280 is dividing by 256, then by 255
			out_data.prod_q <= mq_w[23:8];
			out_data.prod_t <= mt_w[23:8];
		end
	end

endmodule

@@ src/hsv2a_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2a_scale
// Stage 3: divides the brightness products by full scale to get p, q, t.
// ----------------------------------------------------------------------------
module hsv2a_scale (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  hsv2a_pkg::s2_data_t  in_data,
	output logic                 out_valid,
	output hsv2a_pkg::s3_data_t  out_data
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.alpha  <= in_data.alpha;
			out_data.sector <= in_data.sector;
			out_data.bright <= in_data.bright;
			out_data.term_p <= hsv2a_pkg::div255(in_data.prod_p);
			out_data.term_q <= hsv2a_pkg::div255(in_data.prod_q);
			out_data.term_t <= hsv2a_pkg::div255(in_data.prod_t);
		end
	end

	// color terms never exceed brightness, and p is the floor of the three
	a_p_le_v: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.term_p <= out_data.bright)
		else $error("p above brightness");
	a_q_ge_p: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.term_q >= out_data.term_p && out_data.term_q <= out_data.bright))
		else $error("q out of range");
	a_t_ge_p: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.term_t >= out_data.term_p && out_data.term_t <= out_data.bright))
		else $error("t out of range");

endmodule

@@ src/hsv2a_mux.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2a_mux
// Stage 4: sector channel select and ARGB packing into the output register.
// ----------------------------------------------------------------------------
module hsv2a_mux (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  hsv2a_pkg::s3_data_t  in_data,
	output logic                 out_valid,
	output logic [31:0]          argb_word
);

	logic [7:0] red;
	logic [7:0] grn;
	logic [7:0] blu;

	always_comb begin
		red = '0;
		grn = '0;
		blu = '0;
		case (in_data.sector) inside
			hsv2a_pkg::SEC_R_TO_Y, hsv2a_pkg::SEC_WRAP: begin
				red = in_data.bright; grn = in_data.term_t; blu = in_data.term_p;
			end
			hsv2a_pkg::SEC_Y_TO_G: begin
				red = in_data.term_q; grn = in_data.bright; blu = in_data.term_p;
			end
			hsv2a_pkg::SEC_G_TO_C: begin
				red = in_data.term_p; grn = in_data.bright; blu = in_data.term_t;
			end
			hsv2a_pkg::SEC_C_TO_B: begin
				red = in_data.term_p; grn = in_data.term_q; blu = in_data.bright;
			end
			hsv2a_pkg::SEC_B_TO_M: begin
				red = in_data.term_t; grn = in_data.term_p; blu = in_data.bright;
			end
			hsv2a_pkg::SEC_M_TO_R: begin
				red = in_data.bright; grn = in_data.term_p; blu = in_data.term_q;
			end
			default: begin
				// out-of-range sector: black, alpha kept
				red = '0; grn = '0; blu = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			argb_word <= {in_data.alpha, red, grn, blu};
		end
	end

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(en && in_valid && in_data.sector == hsv2a_pkg::SEC_BLACK) |=> argb_word[23:0] == 24'd0)
		else $error("black sector gave color");
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(en && in_valid) |=> argb_word[31:24] == $past(in_data.alpha))
		else $error("alpha not passed through");
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(en && in_valid && in_data.sector != hsv2a_pkg::SEC_BLACK)
		|=> (argb_word[23:16] == $past(in_data.bright) || argb_word[15:8] == $past(in_data.bright)
			|| argb_word[7:0] == $past(in_data.bright)))
		else $error("no channel at brightness");

endmodule
